/* design/hce_pkg.sv */
// ----------------------------------------------------------------------------
// hce_pkg: shared definitions for the Hill cipher encryptor
// Constants, control word layout, microcode table and small arithmetic
// helpers used by the sequencer, the datapath and the top level.
// ----------------------------------------------------------------------------
package hce_pkg;

    localparam int MAX_BLOCK = 4;
    localparam int ROW_W     = $clog2(MAX_BLOCK);
    localparam int LETTER_W  = 5;
    localparam int FILL_W    = 3;
    localparam int KEY_W     = 20;
    localparam int SUM_W     = 12;
    localparam int STEP_W    = 2;

    localparam logic [LETTER_W-1:0] ALPHABET   = 5'd26;
    localparam logic [LETTER_W-1:0] PAD_LETTER = 5'd23;

    // Configuration register indexes.
    localparam logic [2:0] REG_BLOCK_SIZE    = 3'd0;
    localparam logic [2:0] REG_KEY_ROW_ZERO  = 3'd1;
    localparam logic [2:0] REG_KEY_ROW_ONE   = 3'd2;
    localparam logic [2:0] REG_KEY_ROW_TWO   = 3'd3;
    localparam logic [2:0] REG_KEY_ROW_THREE = 3'd4;

    localparam logic [FILL_W-1:0] BLOCK_SIZE_RESET = 3'd2;

    // Jump conditions of a control word.
    localparam logic [1:0] COND_NEVER     = 2'd0;
    localparam logic [1:0] COND_ALWAYS    = 2'd1;
    localparam logic [1:0] COND_NO_BLOCK  = 2'd2;
    localparam logic [1:0] COND_MORE_ROWS = 2'd3;

    // Program step addresses.
    localparam logic [STEP_W-1:0] STEP_WAIT = 2'd0;
    localparam logic [STEP_W-1:0] STEP_DOT  = 2'd1;
    localparam logic [STEP_W-1:0] STEP_EMIT = 2'd2;
    localparam logic [STEP_W-1:0] STEP_END  = 2'd3;

    typedef struct packed {
        logic              in_ready;
        logic              dot;
        logic              wait_out;
        logic              emit;
        logic              finish;
        logic [1:0]        cond;
        logic [STEP_W-1:0] target;
    } uword_t;

    // Control strobes from the sequencer to the datapath.
    typedef struct packed {
        logic in_ready;
        logic dot;
        logic emit;
        logic finish;
    } ctrl_t;

    // Status flags from the datapath back to the sequencer.
    typedef struct packed {
        logic block_start;
        logic more_rows;
        logic out_busy;
    } status_t;

    // The microprogram. Each row is one step of the block encryption.
    function automatic uword_t ucode_rom(input logic [STEP_W-1:0] step);
        uword_t w;
        w = '0;
        unique case (step)
            STEP_WAIT:
            begin
                w.in_ready = 1'b1;
                w.cond     = COND_NO_BLOCK;
                w.target   = STEP_WAIT;
            end
            STEP_DOT:
            begin
                w.dot    = 1'b1;
                w.cond   = COND_NEVER;
                w.target = STEP_WAIT;
            end
            STEP_EMIT:
            begin
                w.wait_out = 1'b1;
                w.emit     = 1'b1;
                w.cond     = COND_MORE_ROWS;
                w.target   = STEP_DOT;
            end
            STEP_END:
            begin
                w.finish = 1'b1;
                w.cond   = COND_ALWAYS;
                w.target = STEP_WAIT;
            end
        endcase
        return w;
    endfunction

    // Block size as used: zero acts as one, anything above MAX_BLOCK as MAX_BLOCK.
    function automatic logic [FILL_W-1:0] eff_size(input logic [FILL_W-1:0] bs);
        logic [FILL_W-1:0] n;
        n = bs;
        if (n == '0)
        begin
            n = FILL_W'(1);
        end
        if (n > FILL_W'(MAX_BLOCK))
        begin
            n = FILL_W'(MAX_BLOCK);
        end
        return n;
    endfunction

    // Reduces a dot product below 26 * 128 modulo 26 by restoring subtraction.
    function automatic logic [LETTER_W-1:0] mod26(input logic [SUM_W-1:0] x);
        logic [SUM_W-1:0] r;
        logic [SUM_W-1:0] d;
        r = x;
        for (int i = 6; i >= 0; i--)
        begin
            d = SUM_W'(ALPHABET) << i;
            if (r >= d)
            begin
                r = r - d;
            end
        end
        return r[LETTER_W-1:0];
    endfunction

endpackage

/* design/hce_sequencer.sv */
// ----------------------------------------------------------------------------
// hce_sequencer: microprogram sequencer
// Holds the step counter, reads the control word from the program table and
// resolves holds and conditional jumps.
// ----------------------------------------------------------------------------
module hce_sequencer
    import hce_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  status_t status,
    output ctrl_t   ctrl
);

    logic [STEP_W-1:0] pc_reg;
    logic [STEP_W-1:0] pc_next;
    uword_t            uw;
    logic              hold;
    logic              jump;

    assign uw   = ucode_rom(pc_reg);
    // A step that delivers a word stalls while the output register is still full.
    assign hold = uw.wait_out & status.out_busy;

    always_comb
    begin
        unique case (uw.cond)
            COND_NEVER:     jump = 1'b0;
            COND_ALWAYS:    jump = 1'b1;
            COND_NO_BLOCK:  jump = ~status.block_start;
            COND_MORE_ROWS: jump = status.more_rows;
        endcase
    end

    always_comb
    begin
        if (hold)
        begin
            pc_next = pc_reg;
        end
        else if (jump)
        begin
            pc_next = uw.target;
        end
        else
        begin
            pc_next = pc_reg + STEP_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= STEP_WAIT;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

    assign ctrl.in_ready = uw.in_ready;
    assign ctrl.dot      = uw.dot;
    assign ctrl.emit     = uw.emit & ~hold;
    assign ctrl.finish   = uw.finish;

endmodule

/* design/hce_datapath.sv */
// ----------------------------------------------------------------------------
// hce_datapath: block buffer, row dot-product unit and output register
// Collects letters, forms one key row times block vector per dot step and
// reduces it modulo 26 into the output register on each emit step.
// ----------------------------------------------------------------------------
module hce_datapath
    import hce_pkg::*;
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  ctrl_t                           ctrl,
    input  logic                            accept,
    input  logic [LETTER_W-1:0]             plain_letter,
    input  logic                            message_end,
    input  logic [FILL_W-1:0]               size_n,
    input  logic [MAX_BLOCK-1:0][KEY_W-1:0] key_rows,
    input  logic                            out_stall,
    output status_t                         status,
    output logic                            out_valid,
    output logic [LETTER_W-1:0]             cipher_letter,
    output logic                            block_last,
    output logic                            message_done
);

    logic [LETTER_W-1:0] buf_reg [MAX_BLOCK];
    logic [FILL_W-1:0]   fill_reg;
    logic [FILL_W-1:0]   fill_next;
    logic                last_reg;
    logic [ROW_W-1:0]    row_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [SUM_W-1:0]    sum_next;
    logic                out_valid_reg;
    logic [LETTER_W-1:0] cipher_reg;
    logic                block_last_reg;
    logic                message_done_reg;
    logic                row_is_last;
    logic [KEY_W-1:0]    key_sel;

    assign fill_next = fill_reg + FILL_W'(1);

    assign status.block_start = accept & ((fill_next >= size_n) | message_end);
    assign status.more_rows   = (FILL_W'(row_reg) + FILL_W'(1)) < size_n;
    assign status.out_busy    = out_valid_reg & out_stall;

    assign row_is_last = (FILL_W'(row_reg) + FILL_W'(1)) == size_n;
    assign key_sel     = key_rows[row_reg];

    // One key row against the block; positions past the held letters read as X.
    always_comb
    begin
        logic [LETTER_W-1:0] k;
        logic [LETTER_W-1:0] v;
        sum_next = '0;
        for (int c = 0; c < MAX_BLOCK; c++)
        begin
            k = key_sel[c*LETTER_W +: LETTER_W];
            if (k >= ALPHABET)
            begin
                k = k - ALPHABET;
            end
            v = (FILL_W'(c) >= fill_reg) ? PAD_LETTER : buf_reg[c];
            if (FILL_W'(c) < size_n)
            begin
                sum_next = sum_next + SUM_W'(10'(k) * 10'(v));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && !fill_reg[FILL_W-1])
        begin
            buf_reg[fill_reg[ROW_W-1:0]] <= plain_letter;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            last_reg <= 1'b0;
            row_reg  <= '0;
        end
        else
        begin
            if (accept)
            begin
                fill_reg <= fill_next;
                last_reg <= message_end;
            end
            else if (ctrl.finish)
            begin
                fill_reg <= '0;
            end
            if (ctrl.finish)
            begin
                row_reg <= '0;
            end
            else if (ctrl.emit)
            begin
                row_reg <= row_reg + ROW_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.dot)
        begin
            sum_reg <= sum_next;
        end
        if (ctrl.emit)
        begin
            cipher_reg       <= mod26(sum_reg);
            block_last_reg   <= row_is_last;
            message_done_reg <= row_is_last & last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign cipher_letter = cipher_reg;
    assign block_last    = block_last_reg;
    assign message_done  = message_done_reg;

endmodule

/* design/hill_cipher_encrypt_unit.sv */
// ----------------------------------------------------------------------------
// hill_cipher_encrypt_unit: Hill cipher encryptor, one letter per word
// Buffers plaintext letters into blocks and emits the key matrix times the
// block vector modulo 26, one cipher letter per output word.
// ----------------------------------------------------------------------------
// Letters coded 0 (A) to 25 (Z) enter one per input word and are held until
// a block of block_size letters is complete, or until a letter carrying
// message_end closes it early, in which case the free positions are padded
// with X. The block is then encrypted one key row at a time by a small
// microprogram: a dot step forms the row sum with four narrow multipliers,
// and an emit step reduces it modulo 26 into the output register. After a
// letter closes a block, the sequencer runs a dot step and an emit step for
// each row through the shared dot-product unit, then a closing step; an emit
// step holds while the output register is still full. Further input is
// held off while a block is encrypted. The last word of a block carries
// block_last, and message_done as well if message_end closed the block.
// Configuration is to be written through a plain write port only while the
// block is idle; the block itself does not enforce this. Index 0 is
// block_size (0 acts as 1, values above 4 act as 4), indexes 1 to 4 are key
// rows 0 to 3 with column 0 in the low five bits; key entries above 25 are
// reduced modulo 26.
// ----------------------------------------------------------------------------
module hill_cipher_encrypt_unit
    import hce_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [KEY_W-1:0]    cfg_wdata,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [LETTER_W-1:0] plain_letter,
    input  logic                message_end,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [LETTER_W-1:0] cipher_letter,
    output logic                block_last,
    output logic                message_done
);

    logic [FILL_W-1:0]               block_size_reg;
    logic [MAX_BLOCK-1:0][KEY_W-1:0] key_rows_reg;
    logic [FILL_W-1:0]               size_n;
    logic                            accept;
    ctrl_t                           ctrl;
    status_t                         status;

    // Configuration registers. Indexes past the last key row are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_size_reg <= BLOCK_SIZE_RESET;
            key_rows_reg   <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_BLOCK_SIZE:    block_size_reg  <= cfg_wdata[FILL_W-1:0];
                REG_KEY_ROW_ZERO:  key_rows_reg[0] <= cfg_wdata;
                REG_KEY_ROW_ONE:   key_rows_reg[1] <= cfg_wdata;
                REG_KEY_ROW_TWO:   key_rows_reg[2] <= cfg_wdata;
                REG_KEY_ROW_THREE: key_rows_reg[3] <= cfg_wdata;
                default:           ;
            endcase
        end
    end

    assign size_n   = eff_size(block_size_reg);
    assign in_stall = ~ctrl.in_ready;
    assign accept   = in_valid & ctrl.in_ready;

    hce_sequencer u_seq
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctrl   (ctrl)
    );

    hce_datapath u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (ctrl),
        .accept        (accept),
        .plain_letter  (plain_letter),
        .message_end   (message_end),
        .size_n        (size_n),
        .key_rows      (key_rows_reg),
        .out_stall     (out_stall),
        .status        (status),
        .out_valid     (out_valid),
        .cipher_letter (cipher_letter),
        .block_last    (block_last),
        .message_done  (message_done)
    );

    // An emit step never overwrites a word that is still waiting to be taken.
    assert_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.emit |-> !status.out_busy)
        else $error("emit step while output register is held");

    // Once a letter closes a block, no further letter is taken in the next cycle.
    assert_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && status.block_start) |=> in_stall)
        else $error("input taken while a block is being encrypted");

    // The closing step always finds the final letter of a block in the output register.
    assert_finish_last: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.finish |-> (out_valid && block_last))
        else $error("block closed without its final letter in the output register");

endmodule

/* tb/tb_hill_cipher_encrypt_unit.sv */
// ----------------------------------------------------------------------------
// tb_hill_cipher_encrypt_unit: self-checking bench for the Hill cipher encryptor
// Feeds plaintext letters through the valid/stall input channel, predicts every
// cipher word from a behavioral copy of the block, and compares each accepted
// output word field by field while both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_hill_cipher_encrypt_unit
    import hce_pkg::*;
();

    // Long receiver hold-off, used once so that the block fills and stalls its input.
    localparam int HOLD_CYCLES   = 300;
    // Cycles allowed after the last expected word before a register write. A
    // closing block ends with its closing step, which this wait covers.
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 20;
    // The longest correct quiet stretch is the hold-off plus a few stalls.
    localparam int QUIET_LIMIT   = 2000;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_WORDS   = 48;

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic [2:0]          cfg_index;
    logic [KEY_W-1:0]    cfg_wdata;
    logic                in_valid;
    logic                in_stall;
    logic [LETTER_W-1:0] plain_letter;
    logic                message_end;
    logic                out_valid;
    logic                out_stall;
    logic [LETTER_W-1:0] cipher_letter;
    logic                block_last;
    logic                message_done;

    // Idling controls shared between the stimulus and the receiver process.
    bit tx_idle;
    bit rx_idle;
    bit hold_request;
    // Letters still to send in the current message; it survives phase changes,
    // so a new block size can land on a partly filled block.
    int msg_left;

    typedef struct packed {
        logic [LETTER_W-1:0] letter;
        logic                block_end;
        logic                msg_end;
    } cipher_word_t;

    // Behavioral copy of the encryptor plus the queue of cipher words it owes.
    class cipher_scoreboard;
        logic [2:0]          size_reg;
        logic [KEY_W-1:0]    key_reg [MAX_BLOCK];
        logic [LETTER_W-1:0] held [MAX_BLOCK];
        int                  held_count;
        cipher_word_t        awaited [$];
        int                  failures;

        function new();
            size_reg = BLOCK_SIZE_RESET;
            foreach (key_reg[i])
            begin
                key_reg[i] = '0;
                held[i]    = '0;
            end
            held_count = 0;
            failures   = 0;
        endfunction

        function void set_register(logic [2:0] index, logic [KEY_W-1:0] value);
            case (index)
                REG_BLOCK_SIZE:    size_reg   = value[2:0];
                REG_KEY_ROW_ZERO:  key_reg[0] = value;
                REG_KEY_ROW_ONE:   key_reg[1] = value;
                REG_KEY_ROW_TWO:   key_reg[2] = value;
                REG_KEY_ROW_THREE: key_reg[3] = value;
                default:           ;
            endcase
        endfunction

        // Key entries are five raw bits; values above 25 are folded back.
        function int key_value(int row, int col);
            return int'(key_reg[row][LETTER_W*col +: LETTER_W]) % int'(ALPHABET);
        endfunction

        function void note_letter(logic [LETTER_W-1:0] letter, logic fin);
            int           n;
            int           sum;
            cipher_word_t w;
            n = int'(size_reg);
            if (n == 0)
                n = 1;
            if (n > MAX_BLOCK)
                n = MAX_BLOCK;
            if (held_count < MAX_BLOCK)
                held[held_count] = letter;
            held_count++;
            if (held_count < n && !fin)
                return;
            // An early close pads the open positions with X. When the size
            // was lowered under a partly filled block, only the first n
            // letters take part and the rest are dropped.
            for (int col = held_count; col < n; col++)
                held[col] = PAD_LETTER;
            for (int row = 0; row < n; row++)
            begin
                sum = 0;
                for (int col = 0; col < n; col++)
                    sum += key_value(row, col) * int'(held[col]);
                w.letter    = LETTER_W'(sum % int'(ALPHABET));
                w.block_end = (row == n - 1);
                w.msg_end   = (row == n - 1) && fin;
                awaited.push_back(w);
            end
            held_count = 0;
        endfunction

        task report_mismatch(string detail);
            $display("mismatch at %0t: %s", $time, detail);
            failures++;
        endtask

        task check_word(logic [LETTER_W-1:0] letter, logic blk, logic msg);
            cipher_word_t want;
            if (awaited.size() == 0)
            begin
                report_mismatch($sformatf("cipher word %0d with nothing expected", letter));
                return;
            end
            want = awaited.pop_front();
            if (letter !== want.letter)
                report_mismatch($sformatf("cipher_letter %0d, expected %0d",
                                          letter, want.letter));
            if (blk !== want.block_end)
                report_mismatch($sformatf("block_last %b, expected %b", blk, want.block_end));
            if (msg !== want.msg_end)
                report_mismatch($sformatf("message_done %b, expected %b",
                                          msg, want.msg_end));
        endtask
    endclass

    cipher_scoreboard cipher_sb;

    hill_cipher_encrypt_unit DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .plain_letter (plain_letter),
        .message_end  (message_end),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .cipher_letter(cipher_letter),
        .block_last   (block_last),
        .message_done (message_done)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    function automatic logic [KEY_W-1:0] key_row(int e3, int e2, int e1, int e0);
        return {LETTER_W'(e3), LETTER_W'(e2), LETTER_W'(e1), LETTER_W'(e0)};
    endfunction

    // One register write. The enable is dropped after the write edge and stays low
    // until the next edge, so back-to-back writes never assign it twice at once.
    task automatic write_reg(input logic [2:0] index, input logic [KEY_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= value;
        @(posedge clk);
        cipher_sb.set_register(index, value);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Random sender gap: most are short, a few long, none when idling is off.
    task automatic sender_gap();
        int n;
        n = 0;
        if (tx_idle && $urandom_range(0, 3) == 0)
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // Offers one letter and holds it steady until the block takes it. The
    // stall seen right after the edge is the value the block sampled there.
    task automatic send_letter(input logic [LETTER_W-1:0] letter, input logic fin);
        in_valid     <= 1'b1;
        plain_letter <= letter;
        message_end  <= fin;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        cipher_sb.note_letter(letter, fin);
        sender_gap();
    endtask

    // Stops sending and waits until every predicted cipher word has come out,
    // then lets the block finish its closing step.
    task automatic drain();
        in_valid <= 1'b0;
        while (cipher_sb.awaited.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Receiver: stall runs of random length, plus one long hold-off on request.
    // The hold-off is counted here, independent of what the sender does.
    initial
    begin : result_stall
        int   run;
        logic level;
        out_stall = 1'b0;
        run       = 0;
        level     = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                level        = 1'b1;
                run          = HOLD_CYCLES;
            end
            else if (run <= 0)
            begin
                if (rx_idle && $urandom_range(0, 2) == 0)
                begin
                    level = 1'b1;
                    run   = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40)
                                                         : $urandom_range(1, 3);
                end
                else
                begin
                    level = 1'b0;
                    run   = $urandom_range(1, 6);
                end
            end
            out_stall <= level;
            run--;
        end
    end

    // Every word accepted on the output side is checked against the oldest
    // prediction.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            cipher_sb.check_word(cipher_letter, block_last, message_done);
    end

    // Watchdog: a long stretch with no word moving on either side means the
    // block has hung or lost a word.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin : stimulus
        int               size;
        int               letter;
        logic [KEY_W-1:0] key;

        cipher_sb    = new();
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_wdata    = '0;
        in_valid     = 1'b0;
        plain_letter = '0;
        message_end  = 1'b0;
        tx_idle      = 1'b1;
        rx_idle      = 1'b1;
        hold_request = 1'b0;
        msg_left     = 0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: block size two and an all-zero key, so every cipher
        // letter is A. Both letter extremes go in.
        send_letter(5'd0, 1'b0);
        send_letter(5'd25, 1'b1);
        drain();

        // One-letter blocks with the largest key entry; the last letter is
        // out of the alphabet and still closes the message.
        write_reg(REG_BLOCK_SIZE, KEY_W'(1));
        write_reg(REG_KEY_ROW_ZERO, key_row(0, 0, 0, 25));
        send_letter(5'd0, 1'b0);
        send_letter(5'd25, 1'b0);
        send_letter(5'd31, 1'b1);
        drain();

        // Four-letter blocks. Row zero holds raw entries of 31 and row three
        // holds entries above 25, both folded modulo 26. A full block with some
        // out-of-range letters, then closes after one and after three letters.
        write_reg(REG_BLOCK_SIZE, KEY_W'(MAX_BLOCK));
        write_reg(REG_KEY_ROW_ZERO, '1);
        write_reg(REG_KEY_ROW_ONE, key_row(25, 25, 25, 25));
        write_reg(REG_KEY_ROW_TWO, key_row(0, 1, 2, 3));
        write_reg(REG_KEY_ROW_THREE, key_row(26, 27, 30, 0));
        send_letter(5'd25, 1'b0);
        send_letter(5'd26, 1'b0);
        send_letter(5'd31, 1'b0);
        send_letter(5'd16, 1'b0);
        send_letter(5'd7, 1'b1);
        send_letter(5'd1, 1'b0);
        send_letter(5'd2, 1'b0);
        send_letter(5'd3, 1'b1);
        drain();

        // A block size of zero acts as one, and seven acts as four.
        write_reg(REG_BLOCK_SIZE, KEY_W'(0));
        send_letter(5'd5, 1'b0);
        send_letter(5'd9, 1'b1);
        drain();
        write_reg(REG_BLOCK_SIZE, KEY_W'(7));
        send_letter(5'd1, 1'b0);
        send_letter(5'd2, 1'b1);
        drain();

        // End of message on the very first letter of a three-letter block.
        write_reg(REG_BLOCK_SIZE, KEY_W'(3));
        send_letter(5'd24, 1'b1);
        drain();

        // Size lowered under a partly filled block: three letters held at size
        // four, then size two; the next letter closes the block with the first
        // two letters. Writes past the register list must change nothing.
        write_reg(REG_BLOCK_SIZE, KEY_W'(MAX_BLOCK));
        send_letter(5'd4, 1'b0);
        send_letter(5'd5, 1'b0);
        send_letter(5'd6, 1'b0);
        drain();
        for (int idx = int'(REG_KEY_ROW_THREE) + 1; idx < 8; idx++)
            write_reg(3'(idx), '1);
        write_reg(REG_BLOCK_SIZE, KEY_W'(2));
        send_letter(5'd7, 1'b0);
        drain();

        // Random phases. Each one loads a new size and key while the block is
        // idle, then streams messages of random length with random letters,
        // mostly inside the alphabet. A message may straddle two phases.
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            drain();
            if (phase == 0)
                size = 1;
            else if (phase == RANDOM_PHASES - 1)
                size = MAX_BLOCK;
            else if ($urandom_range(0, 4) == 0)
                size = $urandom_range(0, 7);
            else
                size = $urandom_range(1, MAX_BLOCK);
            write_reg(REG_BLOCK_SIZE, KEY_W'(size));
            for (int row = 0; row < MAX_BLOCK; row++)
            begin
                case ($urandom_range(0, 7))
                    0:       key = '0;
                    1:       key = '1;
                    default: key = KEY_W'($urandom_range(0, (1 << KEY_W) - 1));
                endcase
                write_reg(3'(int'(REG_KEY_ROW_ZERO) + row), key);
            end
            if ($urandom_range(0, 3) == 0)
                write_reg(3'(int'(REG_KEY_ROW_THREE) + $urandom_range(1, 3)),
                          KEY_W'($urandom_range(0, (1 << KEY_W) - 1)));

            // Phases differ in idling, and the last one runs with none at all.
            tx_idle = (phase % 3 != 1);
            rx_idle = (phase % 4 != 3);

            for (int i = 0; i < PHASE_WORDS; i++)
            begin
                // In phase one the receiver holds off for a long stretch while
                // the sender keeps offering letters without gaps.
                if (phase == 1 && i == 10)
                    hold_request = 1'b1;
                if (msg_left == 0)
                    msg_left = $urandom_range(1, 10);
                letter = ($urandom_range(0, 9) == 0) ? $urandom_range(26, 31)
                                                      : $urandom_range(0, 25);
                send_letter(LETTER_W'(letter), msg_left == 1);
                msg_left--;
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (cipher_sb.failures == 0 && cipher_sb.awaited.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
